### hdl/wav_header_chunk_parser_assert.svh
// Assertion macros for the WAV header parser checker.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef WAV_HEADER_CHUNK_PARSER_ASSERT_SVH
`define WAV_HEADER_CHUNK_PARSER_ASSERT_SVH

// Same-cycle implication.
`define WHCP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define WHCP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/whcp_pkg.sv
// Shared types and constants for the WAV header parser.
// No dependencies; imported by every module of the block.
package whcp_pkg;

  localparam logic [31:0] ID_RIFF         = 32'h5249_4646;
  localparam logic [31:0] ID_FMT          = 32'h666D_7420;
  localparam logic [31:0] ID_DATA         = 32'h6461_7461;
  localparam logic [4:0]  RIFF_SKIP_BYTES = 5'd8;
  localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_WAVE  = 2'd1,
    ST_NO_DATA   = 2'd2,
    ST_FMT_SHORT = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    PH_FIRST_ID   = 4'd0,
    PH_RIFF_SKIP  = 4'd1,
    PH_FMT_ID     = 4'd2,
    PH_FMT_SIZE   = 4'd3,
    PH_FMT_FIELDS = 4'd4,
    PH_SKIP       = 4'd5,
    PH_CHUNK_ID   = 4'd6,
    PH_CHUNK_SIZE = 4'd7,
    PH_DATA_SIZE  = 4'd8,
    PH_DONE       = 4'd9
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
    logic       file_last;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] format_type;
    logic signed [15:0] channel_count;
    logic signed [31:0] sample_rate;
    logic signed [31:0] byte_rate;
    logic [15:0]        block_align;
    logic [15:0]        sample_bits;
    logic [31:0]        data_size;
  } out_t;

  // Head of the byte queue as seen by the parser.
  typedef struct packed {
    logic valid;
    in_t  item;
  } queue_head_t;

endpackage

### hdl/whcp_queue.sv
// Two-entry byte queue between the input port and the parser.
// Depends on whcp_pkg.
module whcp_queue import whcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_t         in_data_i,
  output queue_head_t head_o,
  input  logic        pop_i
);

  in_t        ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push;

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### hdl/whcp_parser.sv
// Chunk parser: walks the RIFF/WAVE structure one byte per cycle unless a held
// result stalls it; keeps the result in an output register. Depends on whcp_pkg.
module whcp_parser import whcp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  queue_head_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_t        out_data_o
);

  phase_e      phase_q, ph, step_phase;
  logic [4:0]  cnt_q, cnt, cnt_inc, cnt_d;
  logic [31:0] id_q, id_next, id_d;
  logic [31:0] len_q, len_next, len_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  fmt_q [16];
  logic        fmt_we;
  logic        four;
  logic        live;
  logic        early_emit;
  status_e     early_status;
  logic        emit;
  status_e     status;
  logic        before_fmt;
  logic        out_valid_q;
  out_t        out_q, res;
  logic [7:0]  b;

  assign b = head_i.item.data_byte;

  // Pop whenever the queue head is valid and the result register is free or being emptied this cycle.
  assign pop_o = head_i.valid && (!out_valid_q || !out_stall_i);

  // A start mark restarts parsing on this very byte.
  assign ph  = head_i.item.file_start ? PH_FIRST_ID : phase_q;
  assign cnt = head_i.item.file_start ? 5'd0 : cnt_q;

  assign cnt_inc  = cnt + 5'd1;
  assign four     = (cnt == 5'd3);
  assign id_next  = {id_q[23:0], b};
  assign len_next = {b, len_q[31:8]};

  // Next state and datapath.
  always_comb begin
    step_phase   = ph;
    cnt_d        = cnt;
    id_d         = id_q;
    len_d        = len_q;
    skip_d       = skip_q;
    fmt_we       = 1'b0;
    live         = 1'b1;
    early_emit   = 1'b0;
    early_status = ST_OK;
    unique case (ph)
      PH_FIRST_ID, PH_FMT_ID: begin
        id_d  = id_next;
        cnt_d = four ? 5'd0 : cnt_inc;
        if (four) begin
          if (ph == PH_FIRST_ID && id_next == ID_RIFF) begin
            step_phase = PH_RIFF_SKIP;
          end else if (id_next == ID_FMT) begin
            step_phase = PH_FMT_SIZE;
          end else begin
            early_emit   = 1'b1;
            early_status = ST_NOT_WAVE;
          end
        end
      end
      PH_RIFF_SKIP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= RIFF_SKIP_BYTES) begin
          cnt_d      = 5'd0;
          step_phase = PH_FMT_ID;
        end
      end
      PH_FMT_SIZE: begin
        len_d = len_next;
        cnt_d = four ? 5'd0 : cnt_inc;
        if (four) begin
          if (len_next < FMT_FIELD_BYTES) begin
            early_emit   = 1'b1;
            early_status = ST_FMT_SHORT;
          end else begin
            step_phase = PH_FMT_FIELDS;
          end
        end
      end
      PH_FMT_FIELDS: begin
        fmt_we = 1'b1;
        cnt_d  = cnt_inc;
        if (cnt == 5'd15) begin
          cnt_d      = 5'd0;
          skip_d     = len_q - FMT_FIELD_BYTES;
          step_phase = (len_q != FMT_FIELD_BYTES) ? PH_SKIP : PH_CHUNK_ID;
        end
      end
      PH_SKIP: begin
        skip_d = skip_q - 32'd1;
        if (skip_q == 32'd1) begin
          step_phase = PH_CHUNK_ID;
        end
      end
      PH_CHUNK_ID: begin
        id_d  = id_next;
        cnt_d = four ? 5'd0 : cnt_inc;
        if (four) begin
          step_phase = (id_next == ID_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
        end
      end
      PH_CHUNK_SIZE: begin
        len_d = len_next;
        cnt_d = four ? 5'd0 : cnt_inc;
        if (four) begin
          skip_d     = len_next;
          step_phase = (len_next != 32'd0) ? PH_SKIP : PH_CHUNK_ID;
        end
      end
      PH_DATA_SIZE: begin
        len_d = len_next;
        cnt_d = four ? 5'd0 : cnt_inc;
        if (four) begin
          early_emit   = 1'b1;
          early_status = ST_OK;
        end
      end
      PH_DONE: begin
        live = 1'b0;
      end
      default: begin
        step_phase = PH_DONE;
        live       = 1'b0;
      end
    endcase
  end

  // Result forming: early exits win, otherwise an end mark closes the file.
  always_comb begin
    before_fmt = (step_phase == PH_FIRST_ID) || (step_phase == PH_RIFF_SKIP) ||
                 (step_phase == PH_FMT_ID);
    emit   = early_emit || (live && head_i.item.file_last);
    status = early_emit ? early_status : (before_fmt ? ST_NOT_WAVE : ST_NO_DATA);
    res    = '0;
    res.status = status;
    if (status == ST_OK) begin
      res.format_type   = {fmt_q[1], fmt_q[0]};
      res.channel_count = {fmt_q[3], fmt_q[2]};
      res.sample_rate   = {fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]};
      res.byte_rate     = {fmt_q[11], fmt_q[10], fmt_q[9], fmt_q[8]};
      res.block_align   = {fmt_q[13], fmt_q[12]};
      res.sample_bits   = {fmt_q[15], fmt_q[14]};
      res.data_size     = len_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      id_q   <= id_d;
      len_q  <= len_d;
      skip_q <= skip_d;
      if (fmt_we) begin
        fmt_q[cnt[3:0]] <= b;
      end
    end
    if (pop_o && emit) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST_ID;
      cnt_q       <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= emit ? PH_DONE : step_phase;
        cnt_q   <= cnt_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/wav_header_chunk_parser.sv
// WAV header parser. Takes one file byte per cycle unless in_stall_o is
// high and gives at most one result per file: the 16 fmt bytes and the data
// chunk size, or an error status. Throughput is one byte per cycle while the
// result side does not stall; an accepted byte is stored in the two-entry
// input queue, and the result register loads on the edge that pops it.
// in_stall_o rises only after the result side has held a result under
// stall, once the queue has filled.
// Depends on whcp_pkg, whcp_queue and whcp_parser.
module wav_header_chunk_parser import whcp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  queue_head_t head;
  logic        pop;

  whcp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  whcp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/whcp_checker.sv
// Port-level checks for the WAV header parser, bound to the top level.
// Depends on whcp_pkg and wav_header_chunk_parser_assert.svh.
`include "wav_header_chunk_parser_assert.svh"

module whcp_checker import whcp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  logic out_held;
  logic err_out;
  logic payload_zero;

  assign out_held     = out_valid_o && out_stall_i;
  assign err_out      = out_valid_o && (out_data_o.status != ST_OK);
  assign payload_zero = (out_data_o.format_type == 16'sd0) &&
                        (out_data_o.channel_count == 16'sd0) &&
                        (out_data_o.sample_rate == 32'sd0) &&
                        (out_data_o.byte_rate == 32'sd0) &&
                        (out_data_o.block_align == 16'd0) &&
                        (out_data_o.sample_bits == 16'd0) &&
                        (out_data_o.data_size == 32'd0);

  `WHCP_ASSERT_NXT(a_out_hold, out_held, out_valid_o, "result dropped under stall")
  `WHCP_ASSERT_NXT(a_out_stable, out_held, $stable(out_data_o), "result changed under stall")
  `WHCP_ASSERT_IMP(a_err_zero, err_out, payload_zero, "error result carries data")
  `WHCP_ASSERT_IMP(a_stall_cause, in_stall_o, $past(out_held), "input stalled without a held result")

endmodule

bind wav_header_chunk_parser whcp_checker u_whcp_checker (.*);
